// ===== rtl/core/lavm_pkg.sv =====
package lavm_pkg;

  // one accepted word: eye point, forward difference, up hint; index 0 is x
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][32:0] dvec;
    logic [2:0][31:0] upv;
  } item_t;

  // one matrix row as it leaves the block
  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] col_a;
    logic [31:0] col_b;
    logic [31:0] col_c;
    logic [31:0] translation;
    logic        last_row;
    logic        degenerate;
  } row_t;

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;

endpackage

// ===== rtl/core/look_at_view_matrix.sv =====
// Right-handed look-at view matrix. Each word taken on start (while busy is low)
// returns three rows on the out_ ports, side, up and negated forward, on
// consecutive cycles marked by out_valid; the receiver cannot hold them off.
// Directions are Q2.30, translations Q16.16 saturated to 32 bits; out_degenerate
// flags a zero-length forward or side vector. The back end's time per item is
// set by the two normalizations (a 32-step square root and a 31-step divide
// each, plus a few shift steps); a zero-length vector skips its normalization.
// A front register and a two-word queue let up to three further words be
// taken while one is in work.
module look_at_view_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_aim_x,
  input  logic signed [31:0] in_aim_y,
  input  logic signed [31:0] in_aim_z,
  input  logic signed [31:0] in_upward_x,
  input  logic signed [31:0] in_upward_y,
  input  logic signed [31:0] in_upward_z,
  output logic               out_valid,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col_a,
  output logic signed [31:0] out_col_b,
  output logic signed [31:0] out_col_c,
  output logic signed [31:0] out_translation,
  output logic               out_last_row,
  output logic               out_degenerate
);

  logic            q_full, q_valid, push, pop;
  lavm_pkg::item_t push_item, head;
  lavm_pkg::row_t  row;

  lavm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .eye_x     (in_eye_x),
    .eye_y     (in_eye_y),
    .eye_z     (in_eye_z),
    .aim_x     (in_aim_x),
    .aim_y     (in_aim_y),
    .aim_z     (in_aim_z),
    .upward_x  (in_upward_x),
    .upward_y  (in_upward_y),
    .upward_z  (in_upward_z),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  lavm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (head)
  );

  lavm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_row   (row)
  );

  assign out_row_index   = row.row_index;
  assign out_col_a       = row.col_a;
  assign out_col_b       = row.col_b;
  assign out_col_c       = row.col_c;
  assign out_translation = row.translation;
  assign out_last_row    = row.last_row;
  assign out_degenerate  = row.degenerate;

endmodule

// ===== rtl/core/lavm_front.sv =====
module lavm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  eye_x,
  input  logic signed [31:0]  eye_y,
  input  logic signed [31:0]  eye_z,
  input  logic signed [31:0]  aim_x,
  input  logic signed [31:0]  aim_y,
  input  logic signed [31:0]  aim_z,
  input  logic signed [31:0]  upward_x,
  input  logic signed [31:0]  upward_y,
  input  logic signed [31:0]  upward_z,
  input  logic                q_full,
  output logic                busy,
  output logic                push,
  output lavm_pkg::item_t     push_item
);

  logic            hold_r, hold_nxt;
  logic            take;
  lavm_pkg::item_t item_r;

  assign push      = hold_r & ~q_full;
  assign busy      = hold_r & q_full;
  assign take      = start & ~busy;
  assign push_item = item_r;

  always_comb begin
    hold_nxt = take | (hold_r & q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.eye     <= {eye_z, eye_y, eye_x};
      item_r.upv     <= {upward_z, upward_y, upward_x};
      item_r.dvec[0] <= {aim_x[31], aim_x} - {eye_x[31], eye_x};
      item_r.dvec[1] <= {aim_y[31], aim_y} - {eye_y[31], eye_y};
      item_r.dvec[2] <= {aim_z[31], aim_z} - {eye_z[31], eye_z};
    end
  end

endmodule

// ===== rtl/core/lavm_queue.sv =====
module lavm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lavm_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output lavm_pkg::item_t head
);

  lavm_pkg::item_t mem_r [2];
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/lavm_norm.sv =====
module lavm_norm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [2:0][63:0] vec,
  output logic             done,
  output logic             ok,
  output logic [2:0][31:0] dir
);

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_ROOT  = 7'b0001000,
    N_PREP  = 7'b0010000,
    N_DIV   = 7'b0100000,
    N_FIN   = 7'b1000000
  } nst_t;

  nst_t             st_r;
  logic [4:0]       cnt_r;
  logic [2:0][62:0] mag_r;
  logic [2:0]       neg_r;
  logic [59:0]      sq_r;
  logic [63:0]      sum_r, x_r, res_r, bit_r;
  logic [30:0]      norm_r;
  logic [2:0][31:0] rem_r;
  logic [2:0][30:0] nb_r, quo_r;
  logic             done_r, ok_r;
  logic [2:0][31:0] dir_r;

  logic [2:0][63:0] absv;
  logic             all_zero;
  logic             hi8, hi1, lo8, lo1;
  logic [1:0]       sq_sel;
  logic [63:0]      trial;
  logic [2:0][60:0] num;
  logic [2:0][32:0] r2;

  assign done = done_r;
  assign ok   = ok_r;
  assign dir  = dir_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absv[i] = vec[i][63] ? (64'd0 - vec[i]) : vec[i];
    end
    all_zero = (absv[0] == 64'd0) && (absv[1] == 64'd0) && (absv[2] == 64'd0);
    hi8 = 1'b0;
    hi1 = 1'b0;
    lo8 = 1'b1;
    lo1 = 1'b1;
    for (int i = 0; i < 3; i++) begin
      hi8 = hi8 | (|mag_r[i][62:38]);
      hi1 = hi1 | (|mag_r[i][62:30]);
      lo8 = lo8 & ~(|mag_r[i][62:21]);
      lo1 = lo1 & ~(|mag_r[i][62:29]);
    end
    sq_sel = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];
    trial  = res_r + bit_r;
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, mag_r[i][29:0], 30'd0} + {31'd0, norm_r[30:1]};
      r2[i]  = {rem_r[i], nb_r[i][30]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        N_IDLE: begin
          if (go) begin
            if (all_zero) begin
              done_r <= 1'b1;
            end else begin
              st_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (!hi1 && !lo1) begin
            st_r <= N_SQ;
          end
        end
        N_SQ:   if (cnt_r[1:0] == 2'd3) st_r <= N_ROOT;
        N_ROOT: if (cnt_r == 5'd31) st_r <= N_PREP;
        N_PREP: st_r <= N_DIV;
        N_DIV:  if (cnt_r == 5'd31) st_r <= N_FIN;
        N_FIN: begin
          done_r <= 1'b1;
          st_r   <= N_IDLE;
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      N_IDLE: begin
        cnt_r <= 5'd0;
        sum_r <= 64'd0;
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= absv[i][62:0];
          neg_r[i] <= vec[i][63];
        end
        if (go && all_zero) begin
          ok_r  <= 1'b0;
          dir_r <= '0;
        end
      end
      N_SHIFT: begin
        // common exponent: bring the largest magnitude into [2^29, 2^30)
        for (int i = 0; i < 3; i++) begin
          priority if (hi8) mag_r[i] <= {8'd0, mag_r[i][62:8]};
          else if (hi1)     mag_r[i] <= {1'b0, mag_r[i][62:1]};
          else if (lo8)     mag_r[i] <= {mag_r[i][54:0], 8'd0};
          else if (lo1)     mag_r[i] <= {mag_r[i][61:0], 1'b0};
          else              mag_r[i] <= mag_r[i];
        end
      end
      N_SQ: begin
        sq_r <= mag_r[sq_sel][29:0] * mag_r[sq_sel][29:0];
        if (cnt_r[1:0] != 2'd0) begin
          sum_r <= sum_r + {4'd0, sq_r};
        end
        if (cnt_r[1:0] == 2'd3) begin
          x_r   <= sum_r + {4'd0, sq_r};
          res_r <= 64'd0;
          bit_r <= 64'h4000_0000_0000_0000;
          cnt_r <= 5'd0;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
      N_ROOT: begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= {1'b0, res_r[63:1]} + bit_r;
        end else begin
          res_r <= {1'b0, res_r[63:1]};
        end
        bit_r <= {2'd0, bit_r[63:2]};
        cnt_r <= cnt_r + 5'd1;
      end
      N_PREP: begin
        norm_r <= res_r[30:0];
        cnt_r  <= 5'd0;
      end
      N_DIV: begin
        // first pass after PREP still needs the dividend loaded
        cnt_r <= cnt_r + 5'd1;
      end
      N_FIN: begin
        ok_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          dir_r[i] <= neg_r[i] ? (32'd0 - {1'b0, quo_r[i]}) : {1'b0, quo_r[i]};
        end
      end
      default: cnt_r <= 5'd0;
    endcase
  end

  // restoring divide lanes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (st_r == N_DIV && cnt_r == 5'd0) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= {2'd0, num[i][60:31]};
        nb_r[i]  <= num[i][30:0];
        quo_r[i] <= 31'd0;
      end
    end else if (st_r == N_DIV) begin
      for (int i = 0; i < 3; i++) begin
        if (r2[i] >= {2'd0, norm_r}) begin
          rem_r[i] <= 32'(r2[i] - {2'd0, norm_r});
          quo_r[i] <= {quo_r[i][29:0], 1'b1};
        end else begin
          rem_r[i] <= r2[i][31:0];
          quo_r[i] <= {quo_r[i][29:0], 1'b0};
        end
        nb_r[i] <= {nb_r[i][29:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/lavm_back.sv =====
module lavm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  lavm_pkg::item_t q_item,
  output logic            pop,
  output logic            out_valid,
  output lavm_pkg::row_t  out_row
);

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_NF   = 9'b000000010,
    B_X1   = 9'b000000100,
    B_NS   = 9'b000001000,
    B_X2   = 9'b000010000,
    B_UFIX = 9'b000100000,
    B_DOT  = 9'b001000000,
    B_TFIX = 9'b010000000,
    B_EMIT = 9'b100000000
  } bst_t;

  localparam logic [3:0] X_OPS   = 4'd6;
  localparam logic [3:0] DOT_OPS = 4'd9;

  bst_t             st_r;
  logic [3:0]       cnt_r;
  lavm_pkg::item_t  item_r;
  logic             go_r;
  logic [2:0][31:0] f_r, s_r, u_r;
  logic             okf_r, oks_r;
  logic [2:0][63:0] cr_r, t_r;
  logic [2:0][33:0] tmag_r;
  logic [2:0]       tneg_r;
  logic signed [63:0] prod_r;
  logic             ov_r;
  lavm_pkg::row_t   row_r;

  logic             n_done, n_ok;
  logic [2:0][31:0] n_dir;
  logic [2:0][63:0] n_vec;
  logic signed [31:0] mul_a, mul_b;
  logic [3:0]       kc;
  logic [1:0]       ia, ib, cr_dst, drow_c, dcol_c, drow_i, dcol_i, er;
  logic [31:0]      tr_sel;
  logic [33:0]      tm;

  function automatic logic [1:0] xa_idx(input logic [3:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0: r = 2'd1;
      4'd1: r = 2'd2;
      4'd2: r = 2'd2;
      4'd3: r = 2'd0;
      4'd4: r = 2'd0;
      4'd5: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] xb_idx(input logic [3:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0: r = 2'd2;
      4'd1: r = 2'd1;
      4'd2: r = 2'd0;
      4'd3: r = 2'd2;
      4'd4: r = 2'd1;
      4'd5: r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] d_row(input logic [3:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd1, 4'd2: r = lavm_pkg::ROW_SIDE;
      4'd3, 4'd4, 4'd5: r = lavm_pkg::ROW_UP;
      default:          r = lavm_pkg::ROW_FWD;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] d_col(input logic [3:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // s x f comes in Q4.60: round magnitude to Q2.30, clamp to unit
  function automatic logic [31:0] round_dir(input logic [63:0] v);
    logic [63:0] m;
    logic [33:0] r;
    logic [31:0] c;
    m = v[63] ? (64'd0 - v) : v;
    r = 34'((m + 64'd536870912) >> 30);
    c = (r > 34'd1073741824) ? 32'd1073741824 : r[31:0];
    return v[63] ? (32'd0 - c) : c;
  endfunction

  lavm_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .vec   (n_vec),
    .done  (n_done),
    .ok    (n_ok),
    .dir   (n_dir)
  );

  assign pop       = (st_r == B_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_row   = row_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_vec[i] = (st_r == B_NS) ? cr_r[i] : {{31{item_r.dvec[i][32]}}, item_r.dvec[i]};
    end
    kc     = cnt_r - 4'd1;
    ia     = xa_idx(cnt_r);
    ib     = xb_idx(cnt_r);
    cr_dst = kc[2:1];
    drow_i = d_row(cnt_r);
    dcol_i = d_col(cnt_r);
    drow_c = d_row(kc);
    dcol_c = d_col(kc);
    er     = cnt_r[1:0];
    if (st_r == B_X1) begin
      mul_a = $signed(f_r[ia]);
      mul_b = $signed(item_r.upv[ib]);
    end else if (st_r == B_X2) begin
      mul_a = $signed(s_r[ia]);
      mul_b = $signed(f_r[ib]);
    end else begin
      priority if (drow_i == lavm_pkg::ROW_SIDE) mul_a = $signed(s_r[dcol_i]);
      else if (drow_i == lavm_pkg::ROW_UP)       mul_a = $signed(u_r[dcol_i]);
      else                                       mul_a = $signed(f_r[dcol_i]);
      mul_b = $signed(item_r.eye[dcol_i]);
    end
    tm = tmag_r[er];
    if (tneg_r[er]) begin
      tr_sel = (tm > 34'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - tm[31:0]);
    end else begin
      tr_sel = (tm > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : tm[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      go_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      ov_r <= 1'b0;
      unique case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            st_r <= B_NF;
            go_r <= 1'b1;
          end
        end
        B_NF:   if (n_done) st_r <= B_X1;
        B_X1: begin
          if (cnt_r == X_OPS) begin
            st_r <= B_NS;
            go_r <= 1'b1;
          end
        end
        B_NS:   if (n_done) st_r <= B_X2;
        B_X2:   if (cnt_r == X_OPS) st_r <= B_UFIX;
        B_UFIX: st_r <= B_DOT;
        B_DOT:  if (cnt_r == DOT_OPS) st_r <= B_TFIX;
        B_TFIX: st_r <= B_EMIT;
        B_EMIT: begin
          ov_r <= 1'b1;
          if (cnt_r == 4'd2) st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (st_r)
      B_IDLE: begin
        cnt_r <= 4'd0;
        if (q_valid) item_r <= q_item;
      end
      B_NF: begin
        cnt_r <= 4'd0;
        if (n_done) begin
          f_r   <= n_dir;
          okf_r <= n_ok;
        end
      end
      B_NS: begin
        cnt_r <= 4'd0;
        if (n_done) begin
          s_r   <= n_dir;
          oks_r <= n_ok;
        end
      end
      B_X1, B_X2: begin
        if (cnt_r != 4'd0) begin
          if (!kc[0]) cr_r[cr_dst] <= prod_r;
          else        cr_r[cr_dst] <= cr_r[cr_dst] - prod_r;
        end
        cnt_r <= (cnt_r == X_OPS) ? 4'd0 : cnt_r + 4'd1;
      end
      B_UFIX: begin
        cnt_r <= 4'd0;
        for (int i = 0; i < 3; i++) u_r[i] <= round_dir(cr_r[i]);
      end
      B_DOT: begin
        if (cnt_r != 4'd0) begin
          if (dcol_c == 2'd0) t_r[drow_c] <= prod_r;
          else                t_r[drow_c] <= t_r[drow_c] + prod_r;
        end
        cnt_r <= (cnt_r == DOT_OPS) ? 4'd0 : cnt_r + 4'd1;
      end
      B_TFIX: begin
        cnt_r <= 4'd0;
        for (int i = 0; i < 3; i++) begin
          tmag_r[i] <= 34'(((t_r[i][63] ? (64'd0 - t_r[i]) : t_r[i])
                           + 64'd536870912) >> 30);
          // side and up rows carry -dot, forward row +dot
          tneg_r[i] <= (i < 2) ? (~t_r[i][63] & (|t_r[i])) : t_r[i][63];
        end
      end
      B_EMIT: begin
        cnt_r               <= cnt_r + 4'd1;
        row_r.row_index     <= er;
        row_r.translation   <= tr_sel;
        row_r.last_row      <= (er == lavm_pkg::ROW_FWD);
        row_r.degenerate    <= ~(okf_r & oks_r);
        priority if (er == lavm_pkg::ROW_SIDE) begin
          row_r.col_a <= s_r[0];
          row_r.col_b <= s_r[1];
          row_r.col_c <= s_r[2];
        end else if (er == lavm_pkg::ROW_UP) begin
          row_r.col_a <= u_r[0];
          row_r.col_b <= u_r[1];
          row_r.col_c <= u_r[2];
        end else begin
          row_r.col_a <= 32'd0 - f_r[0];
          row_r.col_b <= 32'd0 - f_r[1];
          row_r.col_c <= 32'd0 - f_r[2];
        end
      end
      default: cnt_r <= 4'd0;
    endcase
  end

endmodule

// ===== dv/look_at_view_matrix_tb.sv =====
`timescale 1ns / 100ps

module look_at_view_matrix_tb;

  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [31:0] aim [3];
    logic signed [31:0] upv [3];
  } camera_t;

  class matrix_board;
    lavm_pkg::row_t rows_due[$];
    int   fails;

    function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
    endfunction

    // shift to [2^29, 2^30), isqrt of sum of squares, rounded divide
    function automatic bit unit_vec(input longint v[3], output longint o[3]);
      longint unsigned mag[3], m, sum, nrm, rem, bitv, q;
      int i;
      int lft;
      int rgt;
      m = 0;
      lft = 0;
      rgt = 0;
      for (i = 0; i < 3; i++) begin
        mag[i] = abs64(v[i]);
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        o = '{0, 0, 0};
        return 0;
      end
      while (m >= (64'd1 << 30)) begin m >>= 1; rgt++; end
      while (m < (64'd1 << 29)) begin m <<= 1; lft++; end
      sum = 0;
      for (i = 0; i < 3; i++) begin
        mag[i] = (mag[i] >> rgt) << lft;
        sum += mag[i] * mag[i];
      end
      nrm = 0;
      rem = sum;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= nrm + bitv) begin
          rem -= nrm + bitv;
          nrm = (nrm >> 1) + bitv;
        end else begin
          nrm >>= 1;
        end
        bitv >>= 2;
      end
      for (i = 0; i < 3; i++) begin
        q = ((mag[i] << 30) + (nrm >> 1)) / nrm;
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function automatic longint round_shift(longint v, int sh);
      longint unsigned mg;
      mg = (abs64(v) + (64'd1 << (sh - 1))) >> sh;
      return v < 0 ? -longint'(mg) : longint'(mg);
    endfunction

    function automatic logic [31:0] eye_offset(longint d[3], longint e[3], bit neg);
      longint t;
      t = d[0] * e[0] + d[1] * e[1] + d[2] * e[2];
      if (neg) t = -t;
      t = round_shift(t, 30);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t[31:0];
    endfunction

    function void note_word(camera_t c);
      longint e[3], dv[3], up[3], f[3], sr[3], s[3], u[3], nf[3];
      bit okf;
      bit oks;
      lavm_pkg::row_t r;
      int i;
      for (i = 0; i < 3; i++) begin
        e[i] = c.eye[i];
        dv[i] = longint'(c.aim[i]) - e[i];
        up[i] = c.upv[i];
      end
      okf = unit_vec(dv, f);
      sr[0] = f[1] * up[2] - f[2] * up[1];
      sr[1] = f[2] * up[0] - f[0] * up[2];
      sr[2] = f[0] * up[1] - f[1] * up[0];
      oks = unit_vec(sr, s);
      u[0] = s[1] * f[2] - s[2] * f[1];
      u[1] = s[2] * f[0] - s[0] * f[2];
      u[2] = s[0] * f[1] - s[1] * f[0];
      for (i = 0; i < 3; i++) begin
        u[i] = round_shift(u[i], 30);
        if (u[i] > (64'sd1 << 30)) u[i] = 64'sd1 << 30;
        if (u[i] < -(64'sd1 << 30)) u[i] = -(64'sd1 << 30);
        nf[i] = -f[i];
      end
      r.degenerate = !(okf && oks);
      r.last_row = 0;
      r.row_index = lavm_pkg::ROW_SIDE;
      r.col_a = s[0][31:0]; r.col_b = s[1][31:0]; r.col_c = s[2][31:0];
      r.translation = eye_offset(s, e, 1);
      rows_due.push_back(r);
      r.row_index = lavm_pkg::ROW_UP;
      r.col_a = u[0][31:0]; r.col_b = u[1][31:0]; r.col_c = u[2][31:0];
      r.translation = eye_offset(u, e, 1);
      rows_due.push_back(r);
      r.row_index = lavm_pkg::ROW_FWD;
      r.last_row = 1;
      r.col_a = nf[0][31:0]; r.col_b = nf[1][31:0]; r.col_c = nf[2][31:0];
      r.translation = eye_offset(f, e, 0);
      rows_due.push_back(r);
    endfunction

    function void check_row(lavm_pkg::row_t got);
      lavm_pkg::row_t x;
      if (rows_due.size() == 0) begin
        $error("unexpected row %0d", got.row_index);
        fails++;
        return;
      end
      x = rows_due.pop_front();
      if (got.row_index !== x.row_index) begin
        $error("row_index exp %0d got %0d", x.row_index, got.row_index); fails++;
      end
      if (got.col_a !== x.col_a) begin
        $error("col_a exp %h got %h", x.col_a, got.col_a); fails++;
      end
      if (got.col_b !== x.col_b) begin
        $error("col_b exp %h got %h", x.col_b, got.col_b); fails++;
      end
      if (got.col_c !== x.col_c) begin
        $error("col_c exp %h got %h", x.col_c, got.col_c); fails++;
      end
      if (got.translation !== x.translation) begin
        $error("translation exp %h got %h", x.translation, got.translation); fails++;
      end
      if (got.last_row !== x.last_row) begin
        $error("last_row exp %0d got %0d", x.last_row, got.last_row); fails++;
      end
      if (got.degenerate !== x.degenerate) begin
        $error("degenerate exp %0d got %0d", x.degenerate, got.degenerate); fails++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] in_eye_x = 0, in_eye_y = 0, in_eye_z = 0;
  logic signed [31:0] in_aim_x = 0, in_aim_y = 0, in_aim_z = 0;
  logic signed [31:0] in_upward_x = 0, in_upward_y = 0, in_upward_z = 0;
  logic out_valid;
  logic [1:0] out_row_index;
  logic signed [31:0] out_col_a, out_col_b, out_col_c, out_translation;
  logic out_last_row, out_degenerate;

  matrix_board board;
  int idle_cycles;
  bit quiet;

  look_at_view_matrix dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_row('{out_row_index, out_col_a, out_col_b, out_col_c,
                        out_translation, out_last_row, out_degenerate});
      idle_cycles <= 0;
    end else if (rst_n && start && !busy) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > STALL_LIMIT) begin
      $display("look_at_view_matrix test failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 8) - 4;
      3: return ($urandom_range(0, 200) - 100) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // holds the word until taken; start goes low only in gaps and drains
  task automatic send_word(camera_t c, bit allow_gap);
    int g;
    if (allow_gap && !quiet && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 5);
      start <= 0;
      repeat (g) @(negedge clk);
    end
    in_eye_x <= c.eye[0]; in_eye_y <= c.eye[1]; in_eye_z <= c.eye[2];
    in_aim_x <= c.aim[0]; in_aim_y <= c.aim[1]; in_aim_z <= c.aim[2];
    in_upward_x <= c.upv[0]; in_upward_y <= c.upv[1]; in_upward_z <= c.upv[2];
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(c);
    @(negedge clk);
  endtask

  task automatic send_vals(int ex, int ey, int ez, int ax, int ay, int az,
                           int ux, int uy, int uz);
    camera_t c;
    c.eye = '{ex, ey, ez};
    c.aim = '{ax, ay, az};
    c.upv = '{ux, uy, uz};
    send_word(c, 0);
  endtask

  task automatic drain();
    start <= 0;
    while (board.rows_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    camera_t c;
    int i;
    int k;
    int lo;
    int hi;
    board = new();
    lo = 32'sh80000000;
    hi = 32'sh7fffffff;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // ordinary camera, then degenerate cases and extreme coordinates
    send_vals(0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0);
    send_vals(1 << 16, 2 << 16, 3 << 16, 1 << 16, 2 << 16, 3 << 16, 0, 1 << 16, 0);
    send_vals(0, 0, 0, 0, 0, -(1 << 16), 0, 0, 0);
    send_vals(0, 0, 0, 0, 0, -(1 << 16), 0, 0, 7 << 16);
    send_vals(0, 0, 0, 0, 3 << 16, 0, 0, -(1 << 16), 0);
    send_vals(lo, lo, lo, hi, hi, hi, 0, 0, 1 << 16);
    send_vals(hi, hi, hi, lo, lo, lo, lo, hi, 0);
    send_vals(hi, lo, hi, lo, hi, lo, hi, hi, lo);
    send_vals(lo, hi, lo, 0, 0, 0, 1, 0, 0);
    send_vals(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_vals(0, 0, 0, 1, 1, 1, -1, 0, 1);
    send_vals(-1, -1, -1, 0, 0, 0, hi, lo, 1);
    send_vals(hi, hi, hi, 0, 0, 0, 1 << 16, 0, 0);
    drain();

    for (i = 0; i < 180; i++) begin
      quiet = (i >= 150);
      for (k = 0; k < 3; k++) begin
        c.eye[k] = rand_coord();
        c.aim[k] = ($urandom_range(0, 9) == 0) ? c.eye[k] : rand_coord();
        c.upv[k] = rand_coord();
      end
      if ($urandom_range(0, 15) == 0) c.upv = '{0, 0, 0};
      send_word(c, 1);
      if (i == 80) drain();
    end

    drain();
    repeat (400) @(posedge clk);
    if (board.fails == 0 && board.rows_due.size() == 0) begin
      $display("look_at_view_matrix test passed");
    end else begin
      $display("look_at_view_matrix test failed");
    end
    $finish;
  end

endmodule
